[rtl/olad_pkg.sv]
// Package for the ordered list append/delete unit.
// Holds command/result beat types, opcode and status codes, cell control type.
// No dependencies.
package olad_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_DUMP   = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        STAT_FIRST_ADDED = 4'd0,
        STAT_TAIL_ADDED  = 4'd1,
        STAT_EMPTY       = 4'd2,
        STAT_ONLY_DEL    = 4'd3,
        STAT_FIRST_DEL   = 4'd4,
        STAT_NOT_FOUND   = 4'd5,
        STAT_MID_DEL     = 4'd6,
        STAT_LAST_DEL    = 4'd7,
        STAT_FULL        = 4'd8,
        STAT_DUMP_ENTRY  = 4'd9,
        STAT_DUMP_EMPTY  = 4'd10
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] entry;
        logic               last;
    } t_result;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] key;
    } t_cell_ctrl;

endpackage

[rtl/ordered_list_append_delete_unit.sv]
// Top level of the ordered list append/delete unit.
// Depends on olad_pkg and olad_cell.
//
// Keeps up to DEPTH signed 32-bit values in append order in a row of cells.
// Append and delete act on all cells at once: they compare and shift together,
// the result beat shows on o_result with o_strobe in the cycle after the command
// is taken, and busy stays low so a new command can follow in the next cycle.
// A dump of a list of N entries holds busy high while N beats go out: the chain
// rotates one place per cycle and cell 0 is sent out, so the list is back in
// order when the last beat (o_result.last set) leaves. An empty dump gives one
// beat. Mode 3 is dropped with no beat. The receiver cannot stall: every beat
// is valid for exactly the one cycle that o_strobe is high.
module ordered_list_append_delete_unit #(
    parameter int DEPTH = olad_pkg::DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  olad_pkg::t_cmd    i_cmd,
    output logic              o_strobe,
    output olad_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    olad_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_idx, n_idx;       // dump beat number
    logic                 r_strobe, n_strobe;
    olad_pkg::t_result    r_result, n_result;

    olad_pkg::t_cell_ctrl w_ctrl;
    logic                 w_accept;
    logic [DEPTH:0]       w_found;            // prefix-OR of matches along the chain
    logic [DEPTH-1:0]     w_hit_tail;
    logic signed [31:0]   w_entry [DEPTH];

    assign busy     = r_state == olad_pkg::S_DUMP;
    assign w_accept = start & ~busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // cell control
    always_comb begin
        w_ctrl.key = i_cmd.value;
        w_ctrl.op  = olad_pkg::CELL_HOLD;
        if (busy) begin
            w_ctrl.op = olad_pkg::CELL_ROTATE;
        end else if (w_accept) begin
            if (i_cmd.mode == olad_pkg::MODE_APPEND) begin
                w_ctrl.op = olad_pkg::CELL_APPEND;
            end else if (i_cmd.mode == olad_pkg::MODE_DELETE) begin
                w_ctrl.op = olad_pkg::CELL_DELETE;
            end
        end
    end

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_next;
        if (g == DEPTH - 1) begin : g_end
            assign w_next = 32'sd0;
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end
        olad_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_count    (r_count),
            .i_next     (w_next),
            .i_head     (w_entry[0]),
            .i_found    (w_found[g]),
            .o_found    (w_found[g+1]),
            .o_hit_tail (w_hit_tail[g]),
            .o_entry    (w_entry[g])
        );
    end

    // control: next state, count and result beat
    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        n_idx             = r_idx;
        n_strobe          = 1'b0;
        n_result          = r_result;
        n_result.entry    = 32'sd0;
        n_result.last     = 1'b1;
        case (r_state)
            olad_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.mode)
                        olad_pkg::MODE_APPEND: begin
                            n_strobe = 1'b1;
                            if (r_count == '0) begin
                                n_result.status = olad_pkg::STAT_FIRST_ADDED;
                                n_count         = ONE_CNT;
                            end else if (r_count == FULL_CNT) begin
                                n_result.status = olad_pkg::STAT_FULL;
                            end else begin
                                n_result.status = olad_pkg::STAT_TAIL_ADDED;
                                n_count         = r_count + ONE_CNT;
                            end
                        end
                        olad_pkg::MODE_DELETE: begin
                            n_strobe = 1'b1;
                            if (r_count == '0) begin
                                n_result.status = olad_pkg::STAT_EMPTY;
                            end else if (!w_found[DEPTH]) begin
                                n_result.status = olad_pkg::STAT_NOT_FOUND;
                            end else begin
                                n_count = r_count - ONE_CNT;
                                if (r_count == ONE_CNT) begin
                                    n_result.status = olad_pkg::STAT_ONLY_DEL;
                                end else if (w_found[1]) begin
                                    n_result.status = olad_pkg::STAT_FIRST_DEL;
                                end else if (|w_hit_tail) begin
                                    n_result.status = olad_pkg::STAT_LAST_DEL;
                                end else begin
                                    n_result.status = olad_pkg::STAT_MID_DEL;
                                end
                            end
                        end
                        olad_pkg::MODE_DUMP: begin
                            if (r_count == '0) begin
                                n_strobe        = 1'b1;
                                n_result.status = olad_pkg::STAT_DUMP_EMPTY;
                            end else begin
                                n_state = olad_pkg::S_DUMP;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                            n_strobe = 1'b0;   // undefined mode: no beat
                        end
                    endcase
                end
            end
            olad_pkg::S_DUMP: begin
                // cell 0 holds the next entry; chain rotates this cycle
                n_strobe        = 1'b1;
                n_result.status = olad_pkg::STAT_DUMP_ENTRY;
                n_result.entry  = w_entry[0];
                n_result.last   = r_idx == (r_count - ONE_CNT);
                n_idx           = r_idx + ONE_CNT;
                if (n_result.last) begin
                    n_state = olad_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = olad_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= olad_pkg::S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

endmodule

[rtl/olad_cell.sv]
// One storage cell of the ordered list chain.
// Depends on olad_pkg for the cell control type.
module olad_cell #(
    parameter int DEPTH = olad_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  olad_pkg::t_cell_ctrl    i_ctrl,
    input  logic [CNT_W-1:0]        i_count,
    input  logic signed [31:0]      i_next,      // entry of cell IDX+1
    input  logic signed [31:0]      i_head,      // entry of cell 0
    input  logic                    i_found,     // a match sits in a lower cell
    output logic                    o_found,     // match here or below
    output logic                    o_hit_tail,  // first match sits in the tail cell
    output logic signed [31:0]      o_entry
);

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;
    logic               w_occupied;
    logic               w_tail;
    logic               w_match;

    assign w_occupied = IDX_C < i_count;
    assign w_tail     = i_count == IDX_P1;
    assign w_match    = w_occupied && (r_entry == i_ctrl.key);
    assign o_found    = i_found | w_match;
    assign o_hit_tail = w_match & ~i_found & w_tail;
    assign o_entry    = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            olad_pkg::CELL_APPEND: begin
                if (i_count == IDX_C) begin
                    n_entry = i_ctrl.key;
                end
            end
            olad_pkg::CELL_DELETE: begin
                // close the gap: everything from the first match up moves down
                if (o_found) begin
                    n_entry = i_next;
                end
            end
            olad_pkg::CELL_ROTATE: begin
                n_entry = w_tail ? i_head : i_next;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[tb/sv/tb.sv]
// Testbench for ordered_list_append_delete_unit: directed and random command beats.
// A mirror of the list predicts every result beat, which is checked in order.
// Depends on olad_pkg and the RTL of the unit.
module tb;
    import olad_pkg::*;

    localparam int DEPTH         = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS  = 240;
    localparam int PHASE_LEN     = 40;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = DEPTH + 8;
    localparam int REPORT_MAX    = 10;

    // Mode code with no meaning: the unit takes the beat and drops it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_strobe;
    t_result o_result;

    // Mirror of the list contents, head at index 0.
    logic signed [31:0] list_mirror[$];
    // Result beats still owed by the unit, oldest first.
    t_result            owed_beats[$];

    logic signed [31:0] value_pool[8];
    int                 mismatches;
    int                 cycle_count = 0;
    bit                 no_gaps;

    ordered_list_append_delete_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------
    function automatic void owe_beat(t_status st, logic signed [31:0] entry,
                                     logic last);
        t_result r;
        r.status = st;
        r.entry  = entry;
        r.last   = last;
        owed_beats.push_back(r);
    endfunction

    // Applies one accepted command to the mirror and queues the beats it owes.
    function automatic void apply_to_mirror(t_cmd c);
        int      pos;
        int      n;
        t_status st;
        n = list_mirror.size();
        case (c.mode)
            MODE_APPEND: begin
                if (n == 0) begin
                    list_mirror.push_back(c.value);
                    owe_beat(STAT_FIRST_ADDED, '0, 1'b1);
                end else if (n >= DEPTH) begin
                    owe_beat(STAT_FULL, '0, 1'b1);
                end else begin
                    list_mirror.push_back(c.value);
                    owe_beat(STAT_TAIL_ADDED, '0, 1'b1);
                end
            end
            MODE_DELETE: begin
                pos = -1;
                for (int i = 0; i < n; i++) begin
                    if (pos < 0 && list_mirror[i] == c.value) pos = i;
                end
                if (n == 0) begin
                    owe_beat(STAT_EMPTY, '0, 1'b1);
                end else if (pos < 0) begin
                    owe_beat(STAT_NOT_FOUND, '0, 1'b1);
                end else begin
                    // Only-entry wins over head/tail classification.
                    if (n == 1)            st = STAT_ONLY_DEL;
                    else if (pos == 0)     st = STAT_FIRST_DEL;
                    else if (pos == n - 1) st = STAT_LAST_DEL;
                    else                   st = STAT_MID_DEL;
                    list_mirror.delete(pos);
                    owe_beat(st, '0, 1'b1);
                end
            end
            MODE_DUMP: begin
                if (n == 0) begin
                    owe_beat(STAT_DUMP_EMPTY, '0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        owe_beat(STAT_DUMP_ENTRY, list_mirror[i], i == n - 1);
                end
            end
            default: ;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Result checking: the receiver cannot stall, so every strobe is a beat.
    //------------------------------------------------------------------
    task automatic report_mismatch(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display({"tb: mismatch (%s) at cycle %0d: ",
                      "want st=%0d entry=%0d last=%0b, got st=%0d entry=%0d last=%0b"},
                     what, cycle_count, want.status, want.entry, want.last,
                     got.status, got.entry, got.last);
    endtask

    always @(posedge i_clk) begin : beat_check
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (owed_beats.size() == 0) begin
                report_mismatch("beat with nothing owed", '0, o_result);
            end else begin
                want = owed_beats.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", want, o_result);
                else if (o_result.entry !== want.entry)
                    report_mismatch("entry", want, o_result);
                else if (o_result.last !== want.last)
                    report_mismatch("last", want, o_result);
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    // Mostly back-to-back or short gaps, now and then a long pause.
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one command beat. start stays high across back-to-back beats and
    // is only dropped when a gap is taken, so it never toggles within a step.
    task automatic send_cmd(logic [1:0] mode, logic signed [31:0] value);
        int   gap;
        t_cmd c;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        c.mode  = mode;
        c.value = value;
        start <= 1'b1;
        i_cmd <= c;
        // Taken at the first edge with busy low (a dump holds it high).
        do @(posedge i_clk); while (busy);
        apply_to_mirror(c);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return value_pool[$urandom_range(0, 7)];
        if (r == 4) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_empty_list();
        send_cmd(MODE_DUMP, VAL_MAX);
        send_cmd(MODE_DELETE, '0);
        send_cmd(MODE_UNUSED, -32'sd1);
    endtask

    task automatic test_single_entry();
        send_cmd(MODE_APPEND, VAL_MIN);
        // One-entry list, no match: must report not found.
        send_cmd(MODE_DELETE, '0);
        send_cmd(MODE_DELETE, VAL_MIN);
    endtask

    task automatic test_delete_positions();
        send_cmd(MODE_APPEND, VAL_MAX);
        send_cmd(MODE_APPEND, '0);
        send_cmd(MODE_APPEND, -32'sd1);
        send_cmd(MODE_APPEND, 32'sh5555_5555);
        send_cmd(MODE_APPEND, -32'sd1);
        send_cmd(MODE_DUMP, '0);
        // Duplicate key: only the first copy goes, from the middle.
        send_cmd(MODE_DELETE, -32'sd1);
        send_cmd(MODE_DELETE, VAL_MAX);
        send_cmd(MODE_DELETE, -32'sd1);
        send_cmd(MODE_DELETE, 32'shAAAA_AAAA);
    endtask

    task automatic test_full_list();
        while (list_mirror.size() < DEPTH)
            send_cmd(MODE_APPEND, $urandom);
        send_cmd(MODE_APPEND, 32'sh1234_5678);
        send_cmd(MODE_UNUSED, '0);
        send_cmd(MODE_DUMP, '0);
    endtask

    // Phases alternate between growing and shrinking the list so that both
    // the full and the empty ends are reached with random contents.
    task automatic test_random();
        int                 sent;
        int                 r;
        bit                 grow;
        logic [1:0]         mode;
        logic signed [31:0] value;
        sent = 0;
        foreach (value_pool[i]) value_pool[i] = $urandom;
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        while (sent < RANDOM_ITEMS) begin
            grow    = ((sent / PHASE_LEN) % 2) == 0;
            no_gaps = ((sent / PHASE_LEN) % 3) == 2;
            r = $urandom_range(0, 99);
            if (r < 5)                      mode = MODE_UNUSED;
            else if (r < 15)                mode = MODE_DUMP;
            else if (r < (grow ? 80 : 35))  mode = MODE_APPEND;
            else                            mode = MODE_DELETE;
            value = pick_value();
            if (mode == MODE_DELETE && list_mirror.size() > 0 &&
                $urandom_range(0, 9) < 7)
                value = list_mirror[$urandom_range(0, list_mirror.size() - 1)];
            send_cmd(mode, value);
            if (mode != MODE_UNUSED) sent++;
        end
    endtask

    initial begin
        mismatches = 0;
        no_gaps    = 1'b0;
        start     <= 1'b0;
        i_cmd     <= '0;
        i_rst_n   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_single_entry();
        test_delete_positions();
        test_full_list();
        test_random();

        start <= 1'b0;
        while (owed_beats.size() != 0) @(posedge i_clk);
        // Let any stray beat show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && owed_beats.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
